### rtl/core/dua_pkg.sv
// ----------------------------------------------------------------------------
// dua_pkg
// Shared widths, calendar tables and helper functions for the
// days-until-anniversary block.
// ----------------------------------------------------------------------------
package dua_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int ORD_W  = 9;
  localparam int DAYS_W = 22;
  localparam int RES_W  = 9;

  localparam int MAX_YEAR    = 9999;
  localparam int YEAR_CYCLE  = 400;

  localparam logic [MON_W-1:0]  MONTH_JAN = MON_W'(1);
  localparam logic [MON_W-1:0]  MONTH_FEB = MON_W'(2);
  localparam logic [MON_W-1:0]  MONTH_DEC = MON_W'(12);

  localparam logic [ORD_W-1:0]  YEAR_LEN_COMMON = ORD_W'(365);
  localparam logic [ORD_W-1:0]  YEAR_LEN_LEAP   = ORD_W'(366);

  // Residue of a year within the 400-year Gregorian cycle
  localparam logic [RES_W-1:0]  RES_LAST  = RES_W'(YEAR_CYCLE - 1);
  localparam logic [RES_W-1:0]  RES_C100  = RES_W'(100);
  localparam logic [RES_W-1:0]  RES_C200  = RES_W'(200);
  localparam logic [RES_W-1:0]  RES_C300  = RES_W'(300);
  localparam logic [YEAR_W-1:0] CYCLE_Y   = YEAR_W'(YEAR_CYCLE);

  // Per-date check result
  typedef struct packed {
    logic             ok;
    logic [ORD_W-1:0] ord;
  } date_info_t;

  // Leap rule, given the year's residue mod 400
  function automatic logic leap_of_res(input logic [RES_W-1:0] r);
    logic div4;
    div4 = (r[1:0] == 2'b00);
    return (r == '0) || (div4 && (r != RES_C100) && (r != RES_C200) && (r != RES_C300));
  endfunction

  function automatic logic [ORD_W-1:0] year_len(input logic leap);
    return leap ? YEAR_LEN_LEAP : YEAR_LEN_COMMON;
  endfunction

  // Days in month; zero for a month code outside January..December
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                   len = DAY_W'(30);
      4'd2:                                      len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                   len = '0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of month m
  function automatic logic [ORD_W-1:0] days_before(input logic [MON_W-1:0] m);
    logic [ORD_W-1:0] cum;
    unique case (m)
      4'd1:    cum = ORD_W'(0);
      4'd2:    cum = ORD_W'(31);
      4'd3:    cum = ORD_W'(59);
      4'd4:    cum = ORD_W'(90);
      4'd5:    cum = ORD_W'(120);
      4'd6:    cum = ORD_W'(151);
      4'd7:    cum = ORD_W'(181);
      4'd8:    cum = ORD_W'(212);
      4'd9:    cum = ORD_W'(243);
      4'd10:   cum = ORD_W'(273);
      4'd11:   cum = ORD_W'(304);
      4'd12:   cum = ORD_W'(334);
      default: cum = '0;
    endcase
    return cum;
  endfunction

endpackage

### rtl/core/dua_date_chk.sv
// ----------------------------------------------------------------------------
// dua_date_chk
// Checks one date against the Gregorian calendar and forms its ordinal
// within the year, given the year's leap flag and range check.
// ----------------------------------------------------------------------------
module dua_date_chk (
  input  logic [dua_pkg::DAY_W-1:0] day,
  input  logic [dua_pkg::MON_W-1:0] month,
  input  logic                      leap,
  input  logic                      year_ok,
  output dua_pkg::date_info_t       info
);

  logic [dua_pkg::DAY_W-1:0] mlen;
  logic                      month_ok;
  logic                      leap_adj;

  // Validate month and day
  assign mlen     = dua_pkg::month_len(month, leap);
  assign month_ok = (month >= dua_pkg::MONTH_JAN) && (month <= dua_pkg::MONTH_DEC);
  assign info.ok  = year_ok && month_ok && (day != '0) && (day <= mlen);

  // Ordinal: days before the month, leap day after February, then the day
  assign leap_adj = leap && (month > dua_pkg::MONTH_FEB);
  assign info.ord = dua_pkg::days_before(month)
                  + dua_pkg::ORD_W'(leap_adj)
                  + dua_pkg::ORD_W'(day);

endmodule

### rtl/core/days_until_anniversary_date.sv
// ----------------------------------------------------------------------------
// days_until_anniversary_date
// Checks a current and a target date, reports the current day of year and
// leap flag, and counts the days until the target by walking year lengths.
// ----------------------------------------------------------------------------
// Sequence: reduce the current year and then the target year mod 400, check
//   both dates, then walk the years between them when both dates are valid
//   and the target year is later, and present the result beat.
// Flow: one beat at a time; busy stays high until the result cycle
//   ends. The year walk adds one year per cycle through the shared adder,
//   which also does the mod-400 reductions.
// Reset: synchronous, active low; returns to idle, no result pending.
// The result beat lasts one cycle and cannot be stalled by the receiver.
module days_until_anniversary_date (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [dua_pkg::DAY_W-1:0]   in_cur_day,
  input  logic [dua_pkg::MON_W-1:0]   in_cur_month,
  input  logic [dua_pkg::YEAR_W-1:0]  in_cur_year,
  input  logic [dua_pkg::DAY_W-1:0]   in_target_day,
  input  logic [dua_pkg::MON_W-1:0]   in_target_month,
  input  logic [dua_pkg::YEAR_W-1:0]  in_target_year,
  output logic                        out_valid,
  output logic                        out_cur_valid,
  output logic                        out_target_valid,
  output logic                        out_cur_leap,
  output logic [dua_pkg::ORD_W-1:0]   out_day_of_year,
  output logic [dua_pkg::DAYS_W-1:0]  out_days_until,
  output logic                        out_is_today,
  output logic                        out_future_year
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MODC = 3'd1;
  localparam logic [2:0] S_MODT = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [dua_pkg::DAYS_W-1:0] NEG_CYCLE = -dua_pkg::DAYS_W'(dua_pkg::YEAR_CYCLE);

  logic [2:0]                   state_r, state_nxt;
  logic [dua_pkg::DAY_W-1:0]    cd_r, td_r;
  logic [dua_pkg::MON_W-1:0]    cm_r, tm_r;
  logic [dua_pkg::YEAR_W-1:0]   cy_r, ty_r;
  logic [dua_pkg::YEAR_W-1:0]   yr_r, yr_nxt;
  logic [dua_pkg::RES_W-1:0]    rc_r, rc_nxt;
  logic [dua_pkg::RES_W-1:0]    rt_r, rt_nxt;
  logic [dua_pkg::RES_W-1:0]    res_r, res_nxt;
  logic [dua_pkg::DAYS_W-1:0]   acc_r, acc_nxt;
  logic                         cv_r, cv_nxt;
  logic                         tv_r, tv_nxt;
  logic [dua_pkg::ORD_W-1:0]    doy_r, doy_nxt;
  logic                         today_r, today_nxt;
  logic                         fut_r, fut_nxt;

  logic                         accept;
  logic                         leap_c, leap_t;
  logic                         cy_ok, ty_ok;
  logic [dua_pkg::ORD_W-1:0]    ylen_c;
  dua_pkg::date_info_t          cur_info, tgt_info, tin_info;
  logic [dua_pkg::DAYS_W-1:0]   sh_a, sh_b, sh_sum;
  logic [dua_pkg::RES_W-1:0]    res_inc;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Year range and leap flags from the reduced residues
  assign leap_c = dua_pkg::leap_of_res(rc_r);
  assign leap_t = dua_pkg::leap_of_res(rt_r);
  assign cy_ok  = (cy_r != '0) && (cy_r <= dua_pkg::YEAR_W'(dua_pkg::MAX_YEAR));
  assign ty_ok  = (ty_r != '0) && (ty_r <= dua_pkg::YEAR_W'(dua_pkg::MAX_YEAR));
  assign ylen_c = dua_pkg::year_len(leap_c);

  // Current date, target in its own year, target placed in the current year
  dua_date_chk u_chk_cur (
    .day(cd_r), .month(cm_r), .leap(leap_c), .year_ok(cy_ok), .info(cur_info)
  );
  dua_date_chk u_chk_tgt (
    .day(td_r), .month(tm_r), .leap(leap_t), .year_ok(ty_ok), .info(tgt_info)
  );
  dua_date_chk u_chk_tin (
    .day(td_r), .month(tm_r), .leap(leap_c), .year_ok(1'b1), .info(tin_info)
  );

  // Shared adder: subtracts 400 during reduction, adds year lengths in the walk
  always_comb begin
    if (state_r == S_WALK) begin
      sh_a = acc_r;
      sh_b = dua_pkg::DAYS_W'(dua_pkg::year_len(dua_pkg::leap_of_res(res_r)));
    end else begin
      sh_a = dua_pkg::DAYS_W'(yr_r);
      sh_b = NEG_CYCLE;
    end
  end
  assign sh_sum  = sh_a + sh_b;
  assign res_inc = (res_r == dua_pkg::RES_LAST) ? '0 : res_r + dua_pkg::RES_W'(1);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    yr_nxt    = yr_r;
    rc_nxt    = rc_r;
    rt_nxt    = rt_r;
    res_nxt   = res_r;
    acc_nxt   = acc_r;
    cv_nxt    = cv_r;
    tv_nxt    = tv_r;
    doy_nxt   = doy_r;
    today_nxt = today_r;
    fut_nxt   = fut_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          yr_nxt    = in_cur_year;
          state_nxt = S_MODC;
        end
      end
      // Reduce the current year mod 400
      S_MODC: begin
        if (yr_r >= dua_pkg::CYCLE_Y) begin
          yr_nxt = sh_sum[dua_pkg::YEAR_W-1:0];
        end else begin
          rc_nxt    = yr_r[dua_pkg::RES_W-1:0];
          yr_nxt    = ty_r;
          state_nxt = S_MODT;
        end
      end
      // Reduce the target year mod 400
      S_MODT: begin
        if (yr_r >= dua_pkg::CYCLE_Y) begin
          yr_nxt = sh_sum[dua_pkg::YEAR_W-1:0];
        end else begin
          rt_nxt    = yr_r[dua_pkg::RES_W-1:0];
          state_nxt = S_CALC;
        end
      end
      // Check both dates and seed the count
      S_CALC: begin
        cv_nxt    = cur_info.ok;
        tv_nxt    = tgt_info.ok;
        doy_nxt   = cur_info.ok ? cur_info.ord : '0;
        acc_nxt   = '0;
        today_nxt = 1'b0;
        fut_nxt   = 1'b0;
        state_nxt = S_DONE;
        if (cur_info.ok && tgt_info.ok) begin
          if (ty_r > cy_r) begin
            fut_nxt   = 1'b1;
            acc_nxt   = dua_pkg::DAYS_W'(ylen_c) - dua_pkg::DAYS_W'(cur_info.ord)
                      + dua_pkg::DAYS_W'(tgt_info.ord);
            yr_nxt    = cy_r + dua_pkg::YEAR_W'(1);
            res_nxt   = (rc_r == dua_pkg::RES_LAST) ? '0 : rc_r + dua_pkg::RES_W'(1);
            state_nxt = S_WALK;
          end else if (tin_info.ord >= cur_info.ord) begin
            acc_nxt   = dua_pkg::DAYS_W'(tin_info.ord - cur_info.ord);
            today_nxt = (tin_info.ord == cur_info.ord);
          end else begin
            acc_nxt   = dua_pkg::DAYS_W'(ylen_c - (cur_info.ord - tin_info.ord));
          end
        end
      end
      // Add one whole year between the two dates per cycle
      S_WALK: begin
        if (yr_r == ty_r) begin
          state_nxt = S_DONE;
        end else begin
          acc_nxt = sh_sum;
          yr_nxt  = yr_r + dua_pkg::YEAR_W'(1);
          res_nxt = res_inc;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the accepted beat and the working values
  always_ff @(posedge clk) begin
    if (accept) begin
      cd_r <= in_cur_day;
      cm_r <= in_cur_month;
      cy_r <= in_cur_year;
      td_r <= in_target_day;
      tm_r <= in_target_month;
      ty_r <= in_target_year;
    end
    yr_r    <= yr_nxt;
    rc_r    <= rc_nxt;
    rt_r    <= rt_nxt;
    res_r   <= res_nxt;
    acc_r   <= acc_nxt;
    cv_r    <= cv_nxt;
    tv_r    <= tv_nxt;
    doy_r   <= doy_nxt;
    today_r <= today_nxt;
    fut_r   <= fut_nxt;
  end

  // Result beat
  assign out_valid        = (state_r == S_DONE);
  assign out_cur_valid    = cv_r;
  assign out_target_valid = tv_r;
  assign out_cur_leap     = leap_c;
  assign out_day_of_year  = doy_r;
  assign out_days_until   = acc_r;
  assign out_is_today     = today_r;
  assign out_future_year  = fut_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("accepted beat did not raise busy");

  a_today_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_today) |-> (out_days_until == '0))
    else $error("today flag with nonzero count");

  a_future_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_future_year || out_is_today)) |-> (out_cur_valid && out_target_valid))
    else $error("future or today flag with an invalid date");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (yr_r <= ty_r)) else $error("year walk passed the target year");

  a_doy_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_cur_valid) |-> (out_day_of_year == '0 && out_days_until == '0))
    else $error("invalid current date with nonzero ordinal or count");
`endif

endmodule

### tb/sv/days_until_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// days_until_checker
// Watches the date channel and the result strobe of the days-until block,
// predicts each answer from the Gregorian calendar rules and compares it
// field by field with what the block returns, oldest answer first.
// ----------------------------------------------------------------------------
module days_until_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [dua_pkg::DAY_W-1:0]   in_cur_day,
  input  logic [dua_pkg::MON_W-1:0]   in_cur_month,
  input  logic [dua_pkg::YEAR_W-1:0]  in_cur_year,
  input  logic [dua_pkg::DAY_W-1:0]   in_target_day,
  input  logic [dua_pkg::MON_W-1:0]   in_target_month,
  input  logic [dua_pkg::YEAR_W-1:0]  in_target_year,
  input  logic                        out_valid,
  input  logic                        out_cur_valid,
  input  logic                        out_target_valid,
  input  logic                        out_cur_leap,
  input  logic [dua_pkg::ORD_W-1:0]   out_day_of_year,
  input  logic [dua_pkg::DAYS_W-1:0]  out_days_until,
  input  logic                        out_is_today,
  input  logic                        out_future_year,
  output int unsigned                 mismatch_count,
  output int unsigned                 answers_pending
);

  localparam int MAX_REPORTS = 10;

  // Month lengths of a common year, January first
  localparam int unsigned COMMON_MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                     31, 31, 30, 31, 30, 31};

  typedef struct {
    logic                       cur_ok;
    logic                       target_ok;
    logic                       cur_leap;
    logic [dua_pkg::ORD_W-1:0]  day_of_year;
    logic [dua_pkg::DAYS_W-1:0] days_left;
    logic                       today;
    logic                       later_year;
  } date_answer_t;

  date_answer_t date_answers_q[$];
  date_answer_t oldest;

  initial begin
    mismatch_count  = 0;
    answers_pending = 0;
  end

  function automatic bit gregorian_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Zero for a month number outside January..December
  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    if (m < dua_pkg::MONTH_JAN || m > dua_pkg::MONTH_DEC) begin
      return 0;
    end
    if (m == dua_pkg::MONTH_FEB && gregorian_leap(y)) begin
      return 29;
    end
    return COMMON_MONTH_DAYS[m - 1];
  endfunction

  function automatic bit date_is_real(input int unsigned d, input int unsigned m,
                                      input int unsigned y);
    if (y < 1 || y > dua_pkg::MAX_YEAR) begin
      return 1'b0;
    end
    return (d >= 1) && (d <= days_in_month(m, y));
  endfunction

  function automatic int unsigned ordinal_in_year(input int unsigned d, input int unsigned m,
                                                  input int unsigned y);
    int unsigned total;
    total = d;
    for (int unsigned i = 1; i < m && i <= 12; i++) begin
      total += days_in_month(i, y);
    end
    return total;
  endfunction

  // Days in all years 1..y
  function automatic int unsigned days_through_year(input int unsigned y);
    return 365 * y + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic date_answer_t predict_answer(input int unsigned cd, input int unsigned cm,
                                                  input int unsigned cy, input int unsigned td,
                                                  input int unsigned tm, input int unsigned ty);
    date_answer_t a;
    int unsigned  year_days;
    int unsigned  cur_ord;
    int unsigned  tgt_ord;
    int unsigned  span;
    a.cur_ok     = date_is_real(cd, cm, cy);
    a.target_ok  = date_is_real(td, tm, ty);
    a.cur_leap   = gregorian_leap(cy);
    a.today      = 1'b0;
    a.later_year = 1'b0;
    cur_ord      = a.cur_ok ? ordinal_in_year(cd, cm, cy) : 0;
    span         = 0;
    if (a.cur_ok && a.target_ok) begin
      year_days = a.cur_leap ? 366 : 365;
      if (ty > cy) begin
        // rest of this year, whole years between, then into the target year
        a.later_year = 1'b1;
        span = (year_days - cur_ord) + (days_through_year(ty - 1) - days_through_year(cy))
             + ordinal_in_year(td, tm, ty);
      end else begin
        // place the target in the current year; a leap day lands on March 1
        tgt_ord = ordinal_in_year(td, tm, cy);
        span = (tgt_ord >= cur_ord) ? tgt_ord - cur_ord : year_days - (cur_ord - tgt_ord);
        a.today = (span == 0);
      end
    end
    a.day_of_year = cur_ord[dua_pkg::ORD_W-1:0];
    a.days_left   = span[dua_pkg::DAYS_W-1:0];
    return a;
  endfunction

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
    end
  endtask

  // Record each accepted date pair, then check any result beat in this cycle
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      date_answers_q.push_back(predict_answer(in_cur_day, in_cur_month, in_cur_year,
                                              in_target_day, in_target_month,
                                              in_target_year));
    end
    if (rst_n && out_valid) begin
      if (date_answers_q.size() == 0) begin
        note_failure("result beat with no date pair outstanding");
      end else begin
        oldest = date_answers_q.pop_front();
        check_field("cur_valid",    32'(oldest.cur_ok),      32'(out_cur_valid));
        check_field("target_valid", 32'(oldest.target_ok),   32'(out_target_valid));
        check_field("cur_leap",     32'(oldest.cur_leap),    32'(out_cur_leap));
        check_field("day_of_year",  32'(oldest.day_of_year), 32'(out_day_of_year));
        check_field("days_until",   32'(oldest.days_left),   32'(out_days_until));
        check_field("is_today",     32'(oldest.today),       32'(out_is_today));
        check_field("future_year",  32'(oldest.later_year),  32'(out_future_year));
      end
    end
    answers_pending = date_answers_q.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives date pairs into the days-until block: directed calendar corners
// first, then random pairs, mostly well-formed, in bursts with random gaps.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_DATES = 76;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 5000000;

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        start           = 1'b0;
  logic                        busy;
  logic [dua_pkg::DAY_W-1:0]   in_cur_day      = '0;
  logic [dua_pkg::MON_W-1:0]   in_cur_month    = '0;
  logic [dua_pkg::YEAR_W-1:0]  in_cur_year     = '0;
  logic [dua_pkg::DAY_W-1:0]   in_target_day   = '0;
  logic [dua_pkg::MON_W-1:0]   in_target_month = '0;
  logic [dua_pkg::YEAR_W-1:0]  in_target_year  = '0;
  logic                        out_valid;
  logic                        out_cur_valid;
  logic                        out_target_valid;
  logic                        out_cur_leap;
  logic [dua_pkg::ORD_W-1:0]   out_day_of_year;
  logic [dua_pkg::DAYS_W-1:0]  out_days_until;
  logic                        out_is_today;
  logic                        out_future_year;

  int unsigned mismatch_count;
  int unsigned answers_pending;
  int unsigned cycle_count         = 0;
  int unsigned beats_left_in_burst = 1;

  days_until_anniversary_date dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cur_day       (in_cur_day),
    .in_cur_month     (in_cur_month),
    .in_cur_year      (in_cur_year),
    .in_target_day    (in_target_day),
    .in_target_month  (in_target_month),
    .in_target_year   (in_target_year),
    .out_valid        (out_valid),
    .out_cur_valid    (out_cur_valid),
    .out_target_valid (out_target_valid),
    .out_cur_leap     (out_cur_leap),
    .out_day_of_year  (out_day_of_year),
    .out_days_until   (out_days_until),
    .out_is_today     (out_is_today),
    .out_future_year  (out_future_year)
  );

  days_until_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cur_day       (in_cur_day),
    .in_cur_month     (in_cur_month),
    .in_cur_year      (in_cur_year),
    .in_target_day    (in_target_day),
    .in_target_month  (in_target_month),
    .in_target_year   (in_target_year),
    .out_valid        (out_valid),
    .out_cur_valid    (out_cur_valid),
    .out_target_valid (out_target_valid),
    .out_cur_leap     (out_cur_leap),
    .out_day_of_year  (out_day_of_year),
    .out_days_until   (out_days_until),
    .out_is_today     (out_is_today),
    .out_future_year  (out_future_year),
    .mismatch_count   (mismatch_count),
    .answers_pending  (answers_pending)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned last_day(input int unsigned m, input int unsigned y);
    if (m == dua_pkg::MONTH_FEB) begin
      return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // Lean toward century and leap years so the leap rule gets exercised
  function automatic int unsigned pick_year();
    case ($urandom_range(0, 3))
      0:       return 400 * $urandom_range(1, 24);
      1:       return 100 * $urandom_range(1, 99);
      2:       return 4 * $urandom_range(1, 2499);
      default: return $urandom_range(1, dua_pkg::MAX_YEAR);
    endcase
  endfunction

  // Favor the month's last day now and then
  function automatic int unsigned pick_day(input int unsigned m, input int unsigned y);
    return ($urandom_range(0, 3) == 0) ? last_day(m, y) : $urandom_range(1, last_day(m, y));
  endfunction

  function automatic int unsigned years_ahead(input int unsigned y, input int unsigned k);
    return (y + k > dua_pkg::MAX_YEAR) ? dua_pkg::MAX_YEAR : y + k;
  endfunction

  // Present one beat, hold it until taken, then idle between bursts
  task automatic send_dates(input int unsigned cd, input int unsigned cm,
                            input int unsigned cy, input int unsigned td,
                            input int unsigned tm, input int unsigned ty);
    int unsigned gap;
    in_cur_day      <= cd[dua_pkg::DAY_W-1:0];
    in_cur_month    <= cm[dua_pkg::MON_W-1:0];
    in_cur_year     <= cy[dua_pkg::YEAR_W-1:0];
    in_target_day   <= td[dua_pkg::DAY_W-1:0];
    in_target_month <= tm[dua_pkg::MON_W-1:0];
    in_target_year  <= ty[dua_pkg::YEAR_W-1:0];
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    beats_left_in_burst--;
    if (beats_left_in_burst == 0) begin
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      beats_left_in_burst = $urandom_range(1, 12);
    end
  endtask

  initial begin
    int unsigned cd, cm, cy, td, tm, ty;
    int unsigned choice;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    send_dates(0, 0, 0, 0, 0, 0);
    send_dates(31, 15, 16383, 31, 15, 16383);
    send_dates(1, 1, 1, 31, 12, 1);
    send_dates(31, 12, 9999, 1, 1, 9999);
    send_dates(15, 6, 2024, 15, 6, 2024);
    send_dates(31, 12, 2023, 1, 1, 2024);
    send_dates(1, 3, 2025, 29, 2, 2024);
    send_dates(10, 1, 2025, 29, 2, 2024);
    send_dates(29, 2, 2023, 1, 1, 2023);
    send_dates(1, 1, 2023, 29, 2, 2023);
    send_dates(29, 2, 2000, 29, 2, 2000);
    send_dates(29, 2, 1900, 1, 1, 1900);
    send_dates(0, 5, 2020, 1, 1, 2020);
    send_dates(31, 4, 2020, 1, 1, 2020);
    send_dates(1, 0, 2020, 1, 13, 2020);
    send_dates(1, 13, 2020, 1, 15, 2021);
    send_dates(1, 1, 10000, 1, 1, 10000);
    send_dates(1, 1, 9999, 1, 1, 10000);
    send_dates(1, 1, 1, 31, 12, 9999);
    send_dates(31, 12, 2024, 1, 1, 2020);
    send_dates(1, 3, 2024, 29, 2, 2024);
    send_dates(1, 1, 2024, 1, 1, 2025);
    send_dates(28, 2, 2100, 29, 2, 2096);
    send_dates(1, 1, 0, 1, 1, 1);

    // Random pairs: long year walks only on a few beats
    for (int n = 0; n < RANDOM_DATES; n++) begin
      choice = $urandom_range(0, 99);
      cy = pick_year();
      cm = $urandom_range(1, 12);
      cd = pick_day(cm, cy);
      ty = cy;
      tm = $urandom_range(1, 12);
      td = pick_day(tm, ty);
      if (n % 20 == 0) begin
        cy = $urandom_range(1, 200);
        cd = pick_day(cm, cy);
        ty = $urandom_range(9800, dua_pkg::MAX_YEAR);
        td = pick_day(tm, ty);
      end else if (choice < 12) begin
        // noise over the full field widths
        cd = $urandom_range(0, 31);
        cm = $urandom_range(0, 15);
        cy = $urandom_range(0, 16383);
        td = $urandom_range(0, 31);
        tm = $urandom_range(0, 15);
        ty = $urandom_range(0, 16383);
      end else if (choice < 24) begin
        // break one field of an otherwise good pair
        case ($urandom_range(0, 5))
          0: cd = (last_day(cm, cy) < 31) ? last_day(cm, cy) + 1 : 0;
          1: cm = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
          2: cy = $urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383);
          3: td = (last_day(tm, ty) < 31) ? last_day(tm, ty) + 1 : 0;
          4: tm = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
          default: ty = $urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383);
        endcase
      end else begin
        // well-formed pair with a chosen relation between the dates
        case ($urandom_range(0, 5))
          0: begin
            tm = cm;
            td = cd;
          end
          1: ;
          2: begin
            ty = $urandom_range(1, cy);
            td = pick_day(tm, ty);
          end
          3: begin
            ty = years_ahead(cy, $urandom_range(1, 30));
            td = pick_day(tm, ty);
          end
          4: begin
            tm = dua_pkg::MONTH_FEB;
            td = 29;
            ty = 4 * $urandom_range(1, (cy / 4 > 0) ? cy / 4 : 1);
          end
          default: begin
            tm = cm;
            td = cd;
            ty = $urandom_range(0, 1) ? years_ahead(cy, $urandom_range(1, 30))
                                      : $urandom_range(1, cy);
          end
        endcase
      end
      send_dates(cd, cm, cy, td, tm, ty);
    end

    // Drain outstanding answers, then watch for strays
    start <= 1'b0;
    do @(negedge clk); while (answers_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && answers_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
